// ----- hdl/rchm_pkg.sv -----
// ----------------------------------------------------------------------------
// rchm_pkg
// Shared types, register codes and constants of the hydraulic channel mixer.
// ----------------------------------------------------------------------------
package rchm_pkg;

  localparam int PulseW   = 12;
  localparam int SmallW   = 11;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBucketTrim    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegArmTrim       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRipperTrim    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegValveDead     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegValveKnee     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPumpCeil      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPumpRateLimit = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDriveRateLim  = 3'd7;

  // register reset values
  localparam int BucketTrimRst = 0;
  localparam int ArmTrimRst    = 95;
  localparam int RipperTrimRst = 115;
  localparam int ValveDeadRst  = 200;
  localparam int ValveKneeRst  = 300;
  localparam int PumpCeilRst   = 500;
  localparam int PumpRateRst   = 20;
  localparam int DriveRateRst  = 10;

  // pulse constants in microseconds
  localparam int Centre    = 1500;
  localparam int SwitchOn  = 1450;
  localparam int SlewLow   = 1450;
  localparam int SlewHigh  = 1550;
  localparam int AuxHigh   = 2000;
  localparam int AuxLow    = 1000;
  localparam int PumpFloor = 150;
  localparam int DriveDead = 50;
  localparam int DriveSpan = 500;
  localparam int LoadSpan  = 500;
  localparam int PulseMax  = 4095;

  typedef struct packed {
    logic signed [8:0] bucket_trim;
    logic signed [8:0] arm_trim;
    logic signed [8:0] ripper_trim;
    logic [9:0]        valve_dead;
    logic [9:0]        valve_knee;
    logic [9:0]        pump_ceil;
    logic [7:0]        pump_rate_limit;
    logic [7:0]        drive_rate_limit;
  } cfg_t;

  typedef struct packed {
    logic [PulseW-1:0] bucket_stick;
    logic [PulseW-1:0] arm_stick;
    logic [PulseW-1:0] drive_fwd;
    logic [PulseW-1:0] drive_turn;
    logic [PulseW-1:0] ripper_stick;
    logic [PulseW-1:0] light_switch;
    logic [PulseW-1:0] aux_high_switch;
    logic [PulseW-1:0] aux_low_switch;
  } in_frame_t;

  typedef struct packed {
    logic [PulseW-1:0] bucket_pulse;
    logic [PulseW-1:0] arm_pulse;
    logic [PulseW-1:0] ripper_pulse;
    logic [PulseW-1:0] pump_pulse;
    logic [PulseW-1:0] left_drive_pulse;
    logic [PulseW-1:0] right_drive_pulse;
    logic [SmallW-1:0] aux_pulse;
    logic [SmallW-1:0] load_pulse;
    logic              light_on;
    logic              pump_active;
  } out_frame_t;

endpackage

// ----- hdl/rchm_if.sv -----
// ----------------------------------------------------------------------------
// rchm_if
// Valid/ready channels for input frames and mixed output frames.
// ----------------------------------------------------------------------------
interface rchm_in_if;
  import rchm_pkg::*;

  logic      valid;
  logic      ready;
  in_frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rchm_out_if;
  import rchm_pkg::*;

  logic       valid;
  logic       ready;
  out_frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rchm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rchm_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module rchm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rchm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rchm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output rchm_pkg::cfg_t                 cfg_o
);
  import rchm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBucketTrim:    cfg_d.bucket_trim      = $signed(cfg_wdata_i[8:0]);
        RegArmTrim:       cfg_d.arm_trim         = $signed(cfg_wdata_i[8:0]);
        RegRipperTrim:    cfg_d.ripper_trim      = $signed(cfg_wdata_i[8:0]);
        RegValveDead:     cfg_d.valve_dead       = cfg_wdata_i;
        RegValveKnee:     cfg_d.valve_knee       = cfg_wdata_i;
        RegPumpCeil:      cfg_d.pump_ceil        = cfg_wdata_i;
        RegPumpRateLimit: cfg_d.pump_rate_limit  = cfg_wdata_i[7:0];
        RegDriveRateLim:  cfg_d.drive_rate_limit = cfg_wdata_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bucket_trim      <= 9'(BucketTrimRst);
      cfg_q.arm_trim         <= 9'(ArmTrimRst);
      cfg_q.ripper_trim      <= 9'(RipperTrimRst);
      cfg_q.valve_dead       <= 10'(ValveDeadRst);
      cfg_q.valve_knee       <= 10'(ValveKneeRst);
      cfg_q.pump_ceil        <= 10'(PumpCeilRst);
      cfg_q.pump_rate_limit  <= 8'(PumpRateRst);
      cfg_q.drive_rate_limit <= 8'(DriveRateRst);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/rchm_valve_demand.sv -----
// ----------------------------------------------------------------------------
// rchm_valve_demand
// Two-slope deadband curve from one valve stick to its hydraulic demand.
// ----------------------------------------------------------------------------
module rchm_valve_demand (
  input  logic [rchm_pkg::PulseW-1:0] stick_i,
  input  logic [9:0]                  valve_dead_i,
  input  logic [9:0]                  valve_knee_i,
  output logic [rchm_pkg::PulseW-1:0] demand_o
);
  import rchm_pkg::*;

  logic [PulseW-1:0] dev;
  logic [PulseW-1:0] lo_span;
  logic [PulseW-1:0] hi_span;
  logic [10:0]       mid_sum;
  logic [9:0]        mid;
  logic [12:0]       lo_x3;
  logic [12:0]       hi_x3;

  always_comb begin
    dev = (stick_i < PulseW'(Centre)) ? PulseW'(Centre) - stick_i
                                      : stick_i - PulseW'(Centre);
    mid_sum = {1'b0, valve_dead_i} + {1'b0, valve_knee_i};
    mid     = mid_sum[10:1];
    // both spans are only used where they cannot go negative
    lo_span = dev - {2'b00, valve_dead_i};
    hi_span = dev - {2'b00, mid};
    // 150/200 is 3/4 and 150/100 is 3/2
    lo_x3 = {1'b0, lo_span} + {lo_span, 1'b0};
    hi_x3 = {1'b0, hi_span} + {hi_span, 1'b0};
    if (dev < {2'b00, valve_dead_i}) begin
      demand_o = '0;
    end else if (dev < {2'b00, valve_knee_i}) begin
      demand_o = {1'b0, lo_x3[12:2]};
    end else begin
      demand_o = hi_x3[12:1];
    end
  end

endmodule

// ----- hdl/rchm_slew.sv -----
// ----------------------------------------------------------------------------
// rchm_slew
// Per-frame slew limit away from neutral, with bypass on zero rate or state.
// ----------------------------------------------------------------------------
module rchm_slew (
  input  logic [rchm_pkg::PulseW-1:0] target_i,
  input  logic [rchm_pkg::PulseW-1:0] prev_i,
  input  logic [7:0]                  rate_i,
  output logic [rchm_pkg::PulseW-1:0] pulse_o
);
  import rchm_pkg::*;

  logic signed [13:0] lim_lo;
  logic [12:0]        lim_hi;
  logic               bypass;

  always_comb begin
    bypass = (prev_i == '0) || (rate_i == '0);
    lim_lo = $signed({2'b00, prev_i}) - $signed({6'b0, rate_i});
    if (lim_lo > 14'sd1450) begin
      lim_lo = 14'(SlewLow);
    end
    lim_hi = {1'b0, prev_i} + {5'b0, rate_i};
    if (lim_hi < 13'(SlewHigh)) begin
      lim_hi = 13'(SlewHigh);
    end

    pulse_o = target_i;
    // targets sit in 1000..2523, so a taken limit never needs saturation
    if (!bypass) begin
      if (target_i < PulseW'(Centre)) begin
        if ($signed({2'b00, target_i}) < lim_lo) begin
          pulse_o = lim_lo[PulseW-1:0];
        end
      end else if ({1'b0, target_i} > lim_hi) begin
        pulse_o = lim_hi[PulseW-1:0];
      end
    end
  end

endmodule

// ----- hdl/rc_hydraulic_channel_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// rc_hydraulic_channel_mixer_unit
// Mixes one frame of eight servo pulse widths into valve, pump, drive and aux
// outputs.
// ----------------------------------------------------------------------------
// One frame is taken per clock while the input is ready. A frame is
// registered on transfer, mixed in a single pass of logic and lands in the
// output register once that register is free, so a new frame can follow
// while the last result waits to be taken. The pump and drive slew state is
// updated at the same edge that registers each result, so the next frame sees
// it without a bubble; the input only stalls when the output is held off and
// both registers are full. Configuration writes take effect on the next cycle
// and should be made while no frame is in flight.
module rc_hydraulic_channel_mixer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rchm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rchm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rchm_in_if.sink                        in_ch_i,
  rchm_out_if.source                     out_ch_o
);
  import rchm_pkg::*;

  function automatic logic [PulseW-1:0] sat_pulse(input logic signed [13:0] v);
    logic [PulseW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 14'sd4095) begin
      r = PulseW'(PulseMax);
    end else begin
      r = v[PulseW-1:0];
    end
    return r;
  endfunction

  function automatic logic [PulseW-1:0] drive_target(input logic signed [13:0] m);
    logic signed [13:0] sum;
    logic [PulseW-1:0]  r;
    sum = 14'(Centre) + m;
    if (m > -14'sd50 && m < 14'sd50) begin
      r = PulseW'(Centre);
    end else if (m < -14'sd500) begin
      r = PulseW'(Centre - DriveSpan);
    end else if (m > 14'sd500) begin
      r = PulseW'(Centre + DriveSpan);
    end else begin
      r = sum[PulseW-1:0];
    end
    return r;
  endfunction

  cfg_t       cfg;
  in_frame_t  s1_q;
  logic       s1_valid_q;
  out_frame_t out_q, out_d;
  logic       out_valid_q;
  logic       advance;

  logic [PulseW-1:0] pump_prev_q, left_prev_q, right_prev_q;

  logic [PulseW-1:0]  bucket_dem, arm_dem, ripper_dem;
  logic [13:0]        demand_sum;
  logic [14:0]        pump_raw;
  logic [9:0]         pump_off;
  logic [PulseW-1:0]  pump_t;
  logic signed [13:0] fwd, turn, mix_l, mix_r;
  logic [PulseW-1:0]  abs_fwd, abs_turn;
  logic [14:0]        load_sum;
  logic [8:0]         load_c;
  logic [PulseW-1:0]  pump_slew, left_slew, right_slew;
  logic               active;

  rchm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // handshake: the output register frees the input stage on a transfer
  assign advance        = !out_valid_q || out_ch_o.ready;
  assign in_ch_i.ready  = !s1_valid_q || advance;
  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.data  = out_q;

  rchm_valve_demand u_dem_bucket (
    .stick_i (s1_q.bucket_stick), .valve_dead_i (cfg.valve_dead),
    .valve_knee_i (cfg.valve_knee), .demand_o (bucket_dem)
  );
  rchm_valve_demand u_dem_arm (
    .stick_i (s1_q.arm_stick), .valve_dead_i (cfg.valve_dead),
    .valve_knee_i (cfg.valve_knee), .demand_o (arm_dem)
  );
  rchm_valve_demand u_dem_ripper (
    .stick_i (s1_q.ripper_stick), .valve_dead_i (cfg.valve_dead),
    .valve_knee_i (cfg.valve_knee), .demand_o (ripper_dem)
  );

  always_comb begin
    demand_sum = {2'b00, bucket_dem} + {2'b00, arm_dem} + {2'b00, ripper_dem};
    active     = demand_sum != '0;
    pump_raw   = {1'b0, demand_sum} + 15'(PumpFloor);
    pump_off   = (pump_raw > {5'b0, cfg.pump_ceil}) ? cfg.pump_ceil : pump_raw[9:0];
    pump_t     = active ? PulseW'(Centre) + {2'b00, pump_off} : PulseW'(Centre);

    fwd   = $signed({2'b00, s1_q.drive_fwd}) - 14'(Centre);
    turn  = $signed({2'b00, s1_q.drive_turn}) - 14'(Centre);
    mix_l = fwd + turn;
    mix_r = fwd - turn;

    abs_fwd  = (fwd < 0) ? PulseW'(-fwd) : fwd[PulseW-1:0];
    abs_turn = (turn < 0) ? PulseW'(-turn) : turn[PulseW-1:0];
    load_sum = {1'b0, demand_sum} + {3'b000, abs_fwd} + {3'b000, abs_turn};
    load_c   = (load_sum > 15'(LoadSpan)) ? 9'(LoadSpan) : load_sum[8:0];
  end

  rchm_slew u_slew_pump (
    .target_i (pump_t), .prev_i (pump_prev_q),
    .rate_i (cfg.pump_rate_limit), .pulse_o (pump_slew)
  );
  rchm_slew u_slew_left (
    .target_i (drive_target(mix_l)), .prev_i (left_prev_q),
    .rate_i (cfg.drive_rate_limit), .pulse_o (left_slew)
  );
  rchm_slew u_slew_right (
    .target_i (drive_target(mix_r)), .prev_i (right_prev_q),
    .rate_i (cfg.drive_rate_limit), .pulse_o (right_slew)
  );

  always_comb begin
    out_d.bucket_pulse      = sat_pulse($signed({2'b00, s1_q.bucket_stick})
                                        + 14'(cfg.bucket_trim));
    out_d.arm_pulse         = sat_pulse($signed({2'b00, s1_q.arm_stick})
                                        + 14'(cfg.arm_trim));
    out_d.ripper_pulse      = sat_pulse($signed({2'b00, s1_q.ripper_stick})
                                        + 14'(cfg.ripper_trim));
    out_d.pump_pulse        = pump_slew;
    out_d.left_drive_pulse  = left_slew;
    out_d.right_drive_pulse = right_slew;
    if (s1_q.aux_high_switch >= PulseW'(SwitchOn)) begin
      out_d.aux_pulse = SmallW'(AuxHigh);
    end else if (s1_q.aux_low_switch >= PulseW'(SwitchOn)) begin
      out_d.aux_pulse = SmallW'(AuxLow);
    end else begin
      out_d.aux_pulse = SmallW'(Centre);
    end
    out_d.load_pulse  = SmallW'(Centre) + {2'b00, load_c};
    out_d.light_on    = s1_q.light_switch >= PulseW'(SwitchOn);
    out_d.pump_active = active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pump_prev_q  <= '0;
      left_prev_q  <= '0;
      right_prev_q <= '0;
    end else begin
      if (in_ch_i.ready) begin
        s1_valid_q <= in_ch_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      // slew state moves with each registered result
      if (advance && s1_valid_q) begin
        pump_prev_q  <= pump_slew;
        left_prev_q  <= left_slew;
        right_prev_q <= right_slew;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.valid && in_ch_i.ready) begin
      s1_q <= in_ch_i.data;
    end
    if (advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  a_prev_tracks_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pump_prev_q == out_q.pump_pulse)
                 && (left_prev_q == out_q.left_drive_pulse)
                 && (right_prev_q == out_q.right_drive_pulse))
    else $error("slew state does not match the registered result");

  a_idle_pump_neutral : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.pump_active) |-> (out_q.pump_pulse == PulseW'(Centre)))
    else $error("pump pulse off neutral with no valve demand");

  a_load_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.load_pulse >= SmallW'(Centre))
                 && (out_q.load_pulse <= SmallW'(Centre + LoadSpan)))
    else $error("load pulse out of range");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_q))
    else $error("input stage lost a frame while stalled");

endmodule
